/* rtl/core/sdbb_pkg.sv */
// Shared types and constants for the sound chip host bus bridge.
package sdbb_pkg;

   localparam int unsigned RAM_ADDR_BITS_DEF = 16;
   localparam int unsigned READ_DELAY_DEF    = 4;

   localparam int unsigned TIME_BITS = 48;

   // Access kinds
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Port selects
   localparam logic [1:0] PORT_CTRL    = 2'd0;
   localparam logic [1:0] PORT_DATA    = 2'd1;
   localparam logic [1:0] PORT_ADDR_LO = 2'd2;
   localparam logic [1:0] PORT_ADDR_HI = 2'd3;

   // Control byte bit positions
   localparam int unsigned CTRL_BUSY     = 7;
   localparam int unsigned CTRL_RAM_MODE = 6;
   localparam int unsigned CTRL_AUTO_INC = 5;

   localparam logic [7:0] CTRL_READ_ONES = 8'h0F;
   localparam logic [7:0] REBASE_REG     = 8'hE1;

   typedef struct packed {
      logic                 cmd;
      logic [1:0]           port_sel;
      logic [7:0]           write_byte;
      logic [TIME_BITS-1:0] now_time;
      logic [7:0]           chip_reg_value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       chip_read_strobe;
      logic       chip_write_strobe;
      logic [7:0] chip_reg_addr;
      logic [7:0] chip_write_byte;
      logic       volume_strobe;
      logic [3:0] volume_level;
      logic       rate_rebase;
   } rsp_type;

endpackage

/* rtl/core/sound_doc_bus_bridge_core.sv */
// Host bus bridge to a wavetable sound chip: port registers, deferred reads, wave RAM.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_data  (sdbb_pkg::req_type)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (sdbb_pkg::rsp_type)
//
// One item per cycle sustained while rsp_stall stays low and no clearing pass runs; an item's
// result is registered in the output register after the input register and the single update stage.
// The wave RAM read is issued as the item is taken, using the address the item ahead leaves.
// After reset a clearing pass zeroes all 2**RAM_ADDR_BITS bytes of the wave RAM, one byte a cycle,
// with req_stall high throughout.
// A stalled result holds in the output register; the input register keeps one item meanwhile.
module sound_doc_bus_bridge_core #(
   parameter int unsigned RAM_ADDR_BITS = sdbb_pkg::RAM_ADDR_BITS_DEF,
   parameter int unsigned READ_DELAY    = sdbb_pkg::READ_DELAY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sdbb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sdbb_pkg::rsp_type rsp_data
);

   localparam int unsigned RAM_DEPTH = 2 ** RAM_ADDR_BITS;
   localparam int unsigned TB        = sdbb_pkg::TIME_BITS;

   logic                     in_valid_ff;
   sdbb_pkg::req_type        in_item_ff;
   logic                     rsp_valid_ff;
   sdbb_pkg::rsp_type        rsp_ff;
   sdbb_pkg::rsp_type        rsp_in;

   logic [7:0]               ctrl_ff, ctrl_in;
   logic [7:0]               addr_lo_ff, addr_lo_in;
   logic [7:0]               addr_hi_ff, addr_hi_in;
   logic [7:0]               latch_ff, latch_in;
   logic [TB-1:0]            deadline_ff, deadline_in;

   logic                     clearing_ff;
   logic [RAM_ADDR_BITS-1:0] clr_addr_ff;

   logic [7:0]               wave_ram_ff [RAM_DEPTH];
   logic [7:0]               ram_q_ff;
   logic                     byp_hit_ff;
   logic [7:0]               byp_byte_ff;

   logic                     fire;
   logic                     accept;
   logic                     settle_due;
   logic [7:0]               ram_byte;
   logic [15:0]              full_addr;
   logic [15:0]              bumped_addr;
   logic [15:0]              next_addr;
   logic [TB:0]              deadline_sum;
   logic [TB-1:0]            deadline_sat;
   logic                     wr_en;
   logic [RAM_ADDR_BITS-1:0] wr_addr;
   logic [RAM_ADDR_BITS-1:0] rd_addr;
   logic                     mem_we;
   logic [RAM_ADDR_BITS-1:0] mem_wa;
   logic [7:0]               mem_wd;

   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (in_valid_ff && !fire);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ram_byte     = byp_hit_ff ? byp_byte_ff : ram_q_ff;
   assign full_addr    = {addr_hi_ff, addr_lo_ff};
   assign bumped_addr  = full_addr + 16'd1;
   assign next_addr    = {addr_hi_in, addr_lo_in};
   assign rd_addr      = next_addr[RAM_ADDR_BITS-1:0];
   assign wr_addr      = full_addr[RAM_ADDR_BITS-1:0];
   assign settle_due   = ctrl_ff[sdbb_pkg::CTRL_BUSY] && (in_item_ff.now_time >= deadline_ff);
   assign deadline_sum = {1'b0, in_item_ff.now_time} + (TB+1)'(READ_DELAY);
   // Saturate at the top of the timestamp range
   assign deadline_sat = deadline_sum[TB] ? {TB{1'b1}} : deadline_sum[TB-1:0];

   always_comb begin
      ctrl_in     = ctrl_ff;
      addr_lo_in  = addr_lo_ff;
      addr_hi_in  = addr_hi_ff;
      latch_in    = latch_ff;
      deadline_in = deadline_ff;
      rsp_in      = '0;
      wr_en       = 1'b0;
      if (fire) begin
         if (in_item_ff.cmd == sdbb_pkg::CMD_READ) begin
            if (in_item_ff.port_sel == sdbb_pkg::PORT_DATA &&
                !ctrl_ff[sdbb_pkg::CTRL_BUSY]) begin
               ctrl_in[sdbb_pkg::CTRL_BUSY] = 1'b1;
               deadline_in = deadline_sat;
            end else if (settle_due) begin
               // complete the pending read before answering
               ctrl_in[sdbb_pkg::CTRL_BUSY] = 1'b0;
               if (ctrl_ff[sdbb_pkg::CTRL_RAM_MODE]) begin
                  latch_in = ram_byte;
               end else begin
                  latch_in                = in_item_ff.chip_reg_value;
                  rsp_in.chip_read_strobe = 1'b1;
                  rsp_in.chip_reg_addr    = addr_lo_ff;
               end
            end
            unique case (in_item_ff.port_sel)
               sdbb_pkg::PORT_CTRL: begin
                  rsp_in.read_byte = ctrl_in | sdbb_pkg::CTRL_READ_ONES;
               end
               sdbb_pkg::PORT_DATA: begin
                  rsp_in.read_byte = latch_in;
                  if (ctrl_ff[sdbb_pkg::CTRL_AUTO_INC]) begin
                     {addr_hi_in, addr_lo_in} = bumped_addr;
                  end
               end
               sdbb_pkg::PORT_ADDR_LO: begin
                  rsp_in.read_byte = addr_lo_ff;
               end
               sdbb_pkg::PORT_ADDR_HI: begin
                  rsp_in.read_byte = addr_hi_ff;
               end
            endcase
         end else begin
            unique case (in_item_ff.port_sel)
               sdbb_pkg::PORT_CTRL: begin
                  // keep busy, take the rest
                  ctrl_in = {ctrl_ff[sdbb_pkg::CTRL_BUSY], in_item_ff.write_byte[6:0]};
                  rsp_in.volume_strobe = 1'b1;
                  rsp_in.volume_level  = in_item_ff.write_byte[3:0];
               end
               sdbb_pkg::PORT_DATA: begin
                  latch_in = in_item_ff.write_byte;
                  if (ctrl_ff[sdbb_pkg::CTRL_RAM_MODE]) begin
                     wr_en = 1'b1;
                  end else begin
                     rsp_in.chip_write_strobe = 1'b1;
                     rsp_in.chip_reg_addr     = addr_lo_ff;
                     rsp_in.chip_write_byte   = in_item_ff.write_byte;
                     rsp_in.rate_rebase       = (addr_lo_ff == sdbb_pkg::REBASE_REG);
                  end
                  if (ctrl_ff[sdbb_pkg::CTRL_AUTO_INC]) begin
                     {addr_hi_in, addr_lo_in} = bumped_addr;
                  end
               end
               sdbb_pkg::PORT_ADDR_LO: begin
                  addr_lo_in = in_item_ff.write_byte;
               end
               sdbb_pkg::PORT_ADDR_HI: begin
                  addr_hi_in = in_item_ff.write_byte;
               end
            endcase
         end
      end
   end

   // Clearing pass owns the write port after reset
   assign mem_we = clearing_ff || wr_en;
   assign mem_wa = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wd = clearing_ff ? 8'h00 : in_item_ff.write_byte;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wave_ram_ff[mem_wa] <= mem_wd;
      end
      if (accept) begin
         ram_q_ff    <= wave_ram_ff[rd_addr];
         // forward a write landing on the same byte at this edge
         byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
         byp_byte_ff <= in_item_ff.write_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         addr_lo_ff   <= '0;
         addr_hi_ff   <= '0;
         latch_ff     <= '0;
         deadline_ff  <= '0;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == {RAM_ADDR_BITS{1'b1}}) begin
               clearing_ff <= 1'b0;
            end
         end
         if (accept) begin
            in_valid_ff <= 1'b1;
            in_item_ff  <= req_data;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= rsp_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         ctrl_ff     <= ctrl_in;
         addr_lo_ff  <= addr_lo_in;
         addr_hi_ff  <= addr_hi_in;
         latch_ff    <= latch_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule
